FILE: hw/rtl/format_string_integer_printer_assert.svh
// Assertion macros for the integer printf formatter.
// Used by the top level only; needs clk and rst_n in scope.
`ifndef FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH
`define FORMAT_STRING_INTEGER_PRINTER_ASSERT_SVH

// Concurrent check clocked on clk, disabled in reset.
`define FSIP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, also active during reset.
`define FSIP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hw/rtl/fsip_pkg.sv
// Shared types and constants of the integer printf formatter.
// No dependencies.
`default_nettype none
package fsip_pkg;

  localparam int unsigned MAX_FIELD_WIDTH = 62;
  localparam int unsigned FW_W = 6;

  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_LC_X  = 8'h78;
  localparam logic [7:0] CH_UC_X  = 8'h58;
  localparam logic [7:0] CH_LC_D  = 8'h64;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_LC_U  = 8'h75;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_LC_O  = 8'h6f;
  localparam logic [7:0] CH_LC_C  = 8'h63;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_L  = 8'h6c;

  localparam logic [1:0] SIZE_CHAR  = 2'd0;
  localparam logic [1:0] SIZE_SHORT = 2'd1;
  localparam logic [1:0] SIZE_INT   = 2'd2;
  localparam logic [1:0] SIZE_LONG  = 2'd3;

  typedef enum logic [2:0] {
    KIND_NOP = 3'd0,
    KIND_LIT = 3'd1,
    KIND_DEC = 3'd2,
    KIND_HEX = 3'd3,
    KIND_OCT = 3'd4
  } kind_t;

  typedef struct packed {
    logic            restart;
    kind_t           kind;
    logic [31:0]     value;
    logic [1:0]      pfx_n;
    logic [7:0]      sgn_c;
    logic            upper;
    logic            left;
    logic            zpad;
    logic [FW_W-1:0] width;
  } job_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fsip_front.sv
// Front end: directive parser, turns format bytes into output jobs.
// Depends on fsip_pkg.
`default_nettype none
module fsip_front import fsip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_format_char,
  input  wire logic [31:0] in_argument,
  input  wire logic        in_start_req,
  output logic             push,
  output job_t             push_job,
  input  wire logic        push_ready
);

  logic dir_r, zp_r, lj_r, ps_r, alt_r, ws_r;
  logic dir_nxt, zp_nxt, lj_nxt, ps_nxt, alt_nxt, ws_nxt;
  logic [1:0] sz_r, sz_nxt;
  logic [FW_W-1:0] fw_r, fw_nxt;

  logic dir_e, zp_e, lj_e, ps_e, alt_e, ws_e;
  logic [1:0] sz_e;
  logic [FW_W-1:0] fw_e;
  logic [9:0] wsum;
  logic [31:0] mv;
  logic neg;
  logic emit_job;
  logic [7:0] c;
  logic acc;

  assign in_ready = push_ready;
  assign acc = in_valid & in_ready;
  assign c = in_format_char;

  always_comb begin
    dir_e = in_start_req ? 1'b0 : dir_r;
    zp_e  = in_start_req ? 1'b0 : zp_r;
    lj_e  = in_start_req ? 1'b0 : lj_r;
    ps_e  = in_start_req ? 1'b0 : ps_r;
    alt_e = in_start_req ? 1'b0 : alt_r;
    ws_e  = in_start_req ? 1'b0 : ws_r;
    sz_e  = in_start_req ? SIZE_INT : sz_r;
    fw_e  = in_start_req ? '0 : fw_r;

    dir_nxt = dir_e; zp_nxt = zp_e; lj_nxt = lj_e; ps_nxt = ps_e;
    alt_nxt = alt_e; ws_nxt = ws_e; sz_nxt = sz_e; fw_nxt = fw_e;

    unique case (sz_e)
      SIZE_CHAR:  mv = {24'h0, in_argument[7:0]};
      SIZE_SHORT: mv = {16'h0, in_argument[15:0]};
      default:    mv = in_argument;
    endcase
    neg = ((sz_e == SIZE_CHAR) && mv[7]) || ((sz_e == SIZE_SHORT) && mv[15]) ||
          ((sz_e == SIZE_INT) && mv[31]);

    wsum = 10'({4'b0, fw_e} * 10'd10) + 10'(c[3:0]);

    emit_job = 1'b0;
    push_job = '0;
    push_job.restart = in_start_req;
    push_job.kind = KIND_NOP;
    push_job.left = lj_e;
    push_job.zpad = zp_e;
    push_job.width = fw_e;

    if (!dir_e) begin
      if (c == CH_PCT) begin
        dir_nxt = 1'b1; zp_nxt = 1'b0; lj_nxt = 1'b0; ps_nxt = 1'b0;
        alt_nxt = 1'b0; ws_nxt = 1'b0; sz_nxt = SIZE_INT; fw_nxt = '0;
      end else begin
        emit_job = 1'b1;
        push_job.kind = KIND_LIT;
        push_job.value = {24'h0, c};
        push_job.width = '0;
      end
    end else if (c >= CH_ONE && c <= CH_NINE) begin
      fw_nxt = (wsum > 10'(MAX_FIELD_WIDTH)) ? FW_W'(MAX_FIELD_WIDTH) : FW_W'(wsum);
      ws_nxt = 1'b1;
    end else begin
      unique case (c)
        CH_PCT: begin
          emit_job = 1'b1; dir_nxt = 1'b0;
          push_job.kind = KIND_LIT; push_job.value = {24'h0, CH_PCT}; push_job.width = '0;
        end
        CH_HASH:  alt_nxt = 1'b1;
        CH_PLUS:  ps_nxt = 1'b1;
        CH_ZERO: begin
          if (!ws_e) begin
            zp_nxt = 1'b1; ws_nxt = 1'b1;
          end else begin
            fw_nxt = (wsum > 10'(MAX_FIELD_WIDTH)) ? FW_W'(MAX_FIELD_WIDTH) : FW_W'(wsum);
          end
        end
        CH_MINUS: begin
          zp_nxt = 1'b0; lj_nxt = 1'b1;
        end
        CH_LC_H: if (sz_e != SIZE_CHAR) sz_nxt = sz_e - 2'd1;
        CH_LC_L: sz_nxt = (sz_e < SIZE_INT) ? SIZE_INT : SIZE_LONG;
        CH_LC_D, CH_LC_I: begin
          emit_job = 1'b1; dir_nxt = 1'b0;
          push_job.kind = KIND_DEC;
          if (neg) begin
            push_job.value = (sz_e == SIZE_CHAR) ? 32'(0) - (mv | 32'hffffff00) :
                             (sz_e == SIZE_SHORT) ? 32'(0) - (mv | 32'hffff0000) :
                             32'(0) - mv;
            push_job.pfx_n = 2'd1; push_job.sgn_c = CH_MINUS;
          end else begin
            push_job.value = mv;
            push_job.pfx_n = ps_e ? 2'd1 : 2'd0; push_job.sgn_c = CH_PLUS;
          end
        end
        CH_LC_U: begin
          emit_job = 1'b1; dir_nxt = 1'b0;
          push_job.kind = KIND_DEC; push_job.value = mv;
        end
        CH_LC_X, CH_UC_X, CH_LC_P: begin
          emit_job = 1'b1; dir_nxt = 1'b0;
          if (c == CH_LC_P) alt_nxt = 1'b1;
          push_job.kind = KIND_HEX; push_job.value = mv;
          push_job.upper = (c == CH_UC_X);
          push_job.pfx_n = (alt_e || c == CH_LC_P) ? 2'd2 : 2'd0;
        end
        CH_LC_O: begin
          emit_job = 1'b1; dir_nxt = 1'b0;
          push_job.kind = KIND_OCT; push_job.value = in_argument; push_job.width = '0;
        end
        CH_LC_C: begin
          emit_job = 1'b1; dir_nxt = 1'b0;
          push_job.kind = KIND_LIT; push_job.value = {24'h0, in_argument[7:0]};
          push_job.width = '0;
        end
        default: ;
      endcase
    end
    push = acc & (emit_job | in_start_req);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0; zp_r <= 1'b0; lj_r <= 1'b0; ps_r <= 1'b0;
      alt_r <= 1'b0; ws_r <= 1'b0; sz_r <= SIZE_INT; fw_r <= '0;
    end else if (acc) begin
      dir_r <= dir_nxt; zp_r <= zp_nxt; lj_r <= lj_nxt; ps_r <= ps_nxt;
      alt_r <= alt_nxt; ws_r <= ws_nxt; sz_r <= sz_nxt; fw_r <= fw_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fsip_queue.sv
// Two-entry job queue between parser and emitter.
// Depends on fsip_pkg.
`default_nettype none
module fsip_queue import fsip_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  job_t      push_job,
  output logic      push_ready,
  input  wire logic pop,
  output job_t      pop_job,
  output logic      pop_valid
);

  job_t ent_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_job    = ent_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fsip_back.sv
// Back end: digit generation, padding, position count and output register.
// Depends on fsip_pkg.
`default_nettype none
module fsip_back import fsip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        job_valid,
  input  job_t             job,
  output logic             pop,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_char_limit,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             out_last_of_item
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_PADS = 4'b0100,
    S_EMIT = 4'b1000
  } st_t;

  st_t st_r, st_nxt;
  job_t job_r;
  logic [31:0] v_r;
  logic [3:0] cnt_r;
  logic [3:0] dig_r [10];
  logic [1:0] npfx_r;
  logic [FW_W-1:0] nlpad_r, nrpad_r;
  logic [3:0] ndig_r;
  logic [15:0] pos_r, lim_r;
  logic [7:0] och_r;
  logic olast_r, ovalid_r;

  logic [63:0] prod;
  logic [31:0] q, q10;
  logic [3:0] rem;
  logic [3:0] hcnt, ocnt, didx;
  logic [3:0] nib;
  logic [2:0] oct;
  logic [7:0] ch;
  logic [FW_W:0] tot;
  logic [FW_W-1:0] pad;
  logic step, fin, all_zero;

  assign pop = job_valid && (st_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = ovalid_r;
  assign out_char = och_r;
  assign out_last_of_item = olast_r;

  always_comb begin
    hcnt = 4'd1;
    for (int i = 1; i < 8; i++) if (job.value[4*i +: 4] != 4'd0) hcnt = 4'(i + 1);
    ocnt = 4'd1;
    for (int i = 1; i < 11; i++) if ({1'b0, job.value} >> (3*i) != 33'd0) ocnt = 4'(i + 1);
  end

  assign prod = {32'h0, v_r} * 64'h0000_0000_CCCC_CCCD;
  assign q = {3'b000, prod[63:35]};
  assign q10 = (q << 3) + (q << 1);
  assign rem = 4'(v_r - q10);

  assign tot = (FW_W+1)'(cnt_r) +
               (FW_W+1)'((job_r.kind == KIND_DEC) && (job_r.pfx_n == 2'd1));
  assign pad = ({1'b0, job_r.width} > tot) ? FW_W'({1'b0, job_r.width} - tot) : '0;

  assign didx = ndig_r - 4'd1;
  assign nib = 4'(v_r >> {didx[2:0], 2'b00});
  assign oct = 3'({1'b0, v_r} >> (6'(didx) * 6'd3));

  always_comb begin
    fin = 1'b0;
    if (npfx_r != 2'd0) begin
      if (npfx_r == 2'd2) ch = CH_ZERO;
      else if (job_r.kind == KIND_HEX) ch = job_r.upper ? CH_UC_X : CH_LC_X;
      else ch = job_r.sgn_c;
      fin = (npfx_r == 2'd1) && nlpad_r == '0 && ndig_r == '0 && nrpad_r == '0;
    end else if (nlpad_r != '0) begin
      ch = job_r.zpad ? CH_ZERO : CH_SPACE;
      fin = (nlpad_r == FW_W'(1)) && ndig_r == '0 && nrpad_r == '0;
    end else if (ndig_r != '0) begin
      unique case (job_r.kind)
        KIND_DEC: ch = CH_ZERO + 8'(dig_r[didx]);
        KIND_HEX: ch = (nib < 4'd10) ? CH_ZERO + 8'(nib) :
                       (job_r.upper ? CH_UC_A : CH_LC_A) + 8'(nib - 4'd10);
        KIND_OCT: ch = CH_ZERO + 8'(oct);
        default:  ch = v_r[7:0];
      endcase
      fin = (ndig_r == 4'd1) && nrpad_r == '0;
    end else begin
      ch = CH_SPACE;
      fin = (nrpad_r == FW_W'(1));
    end
  end

  assign all_zero = npfx_r == '0 && nlpad_r == '0 && ndig_r == '0 && nrpad_r == '0;
  assign step = (st_r == S_EMIT) && !all_zero && (!ovalid_r || out_ready);

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (pop) st_nxt = (job.kind == KIND_DEC) ? S_DIV : S_PADS;
      S_DIV:  if (q == 32'd0 || cnt_r == 4'd9) st_nxt = S_PADS;
      S_PADS: st_nxt = S_EMIT;
      S_EMIT: if (all_zero) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      job_r <= job;
      v_r <= job.value;
      unique case (job.kind)
        KIND_HEX: cnt_r <= hcnt;
        KIND_OCT: cnt_r <= ocnt;
        KIND_LIT: cnt_r <= 4'd1;
        default:  cnt_r <= 4'd0;
      endcase
    end else if (st_r == S_DIV) begin
      dig_r[cnt_r] <= rem;
      cnt_r <= cnt_r + 4'd1;
      v_r <= q;
    end
    if (step) begin
      och_r <= ch;
      olast_r <= fin || ({1'b0, pos_r} + 17'd1 >= {1'b0, lim_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      pos_r <= '0;
      lim_r <= 16'hffff;
      ovalid_r <= 1'b0;
      npfx_r <= '0; nlpad_r <= '0; ndig_r <= '0; nrpad_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_valid) lim_r <= cfg_char_limit;
      if (pop && job.restart) pos_r <= '0;
      if (st_r == S_PADS) begin
        npfx_r <= job_r.pfx_n;
        ndig_r <= cnt_r;
        nlpad_r <= job_r.left ? '0 : pad;
        nrpad_r <= job_r.left ? pad : '0;
      end
      if (step) ovalid_r <= (pos_r < lim_r);
      else if (out_ready) ovalid_r <= 1'b0;
      if (step) begin
        if (pos_r != 16'hffff) pos_r <= pos_r + 16'd1;
        if (npfx_r != '0) npfx_r <= npfx_r - 2'd1;
        else if (nlpad_r != '0) nlpad_r <= nlpad_r - FW_W'(1);
        else if (ndig_r != '0) ndig_r <= ndig_r - 4'd1;
        else nrpad_r <= nrpad_r - FW_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/format_string_integer_printer.sv
// Top level of the integer printf formatter: parser, job queue, emitter.
// Depends on fsip_pkg, fsip_front, fsip_queue, fsip_back and the assert header.
//
//   channel | ports                                         | dir
//   in      | in_valid in_ready in_format_char in_argument in_start_req | in
//   out     | out_valid out_ready out_char out_last_of_item | out
//   cfg     | cfg_valid cfg_ready cfg_char_limit            | in
//
// Parser takes one byte per cycle while the two-entry queue has room.
// Emitter steps through idle, divide (decimal only), pad setup and emit; it takes the next job only when idle.
// Characters leave one per cycle from a single output register while emitting and out_ready is high.
// Reset is synchronous; no clearing pass. Each side stalls on its own.
`default_nettype none
`include "format_string_integer_printer_assert.svh"
module format_string_integer_printer import fsip_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_format_char,
  input  wire logic [31:0] in_argument,
  input  wire logic        in_start_req,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             out_last_of_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_char_limit
);

  logic push, push_ready, pop, pop_valid;
  job_t push_job, pop_job;

  fsip_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_format_char, .in_argument, .in_start_req,
    .push, .push_job, .push_ready
  );

  fsip_queue u_queue (
    .clk, .rst_n, .push, .push_job, .push_ready, .pop, .pop_job, .pop_valid
  );

  fsip_back u_back (
    .clk, .rst_n, .job_valid(pop_valid), .job(pop_job), .pop,
    .cfg_valid, .cfg_ready, .cfg_char_limit,
    .out_valid, .out_ready, .out_char, .out_last_of_item
  );

  `FSIP_ASSERT(a_push_room, push |-> push_ready, "job pushed into full queue")
  `FSIP_ASSERT(a_pop_data, pop |-> pop_valid, "job popped from empty queue")
  `FSIP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "output valid after reset")

endmodule
`default_nettype wire
